// ===== rtl/core/itp_pkg.sv =====
// Package for the infix to postfix converter: token codes, operator codes,
// error codes, controller states and the command and status structs.
// Depends on nothing; the datapath, controller, top and testbench import it.
package itp_pkg;

    localparam int ITP_STACK_DEPTH = 32;

    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_STAR   = 8'h2A;
    localparam logic [7:0] SYM_SLASH  = 8'h2F;
    localparam logic [7:0] SYM_CARET  = 8'h5E;
    localparam logic [7:0] SYM_LPAREN = 8'h28;
    localparam logic [7:0] SYM_RPAREN = 8'h29;
    localparam logic [7:0] SYM_NONE   = 8'h00;

    typedef logic [2:0] op_code_t;

    localparam op_code_t OP_ADD    = 3'd0;
    localparam op_code_t OP_SUB    = 3'd1;
    localparam op_code_t OP_MUL    = 3'd2;
    localparam op_code_t OP_DIV    = 3'd3;
    localparam op_code_t OP_POW    = 3'd4;
    localparam op_code_t OP_LPAREN = 3'd5;

    typedef logic [1:0] err_code_t;

    localparam err_code_t ERR_NONE     = 2'd0;
    localparam err_code_t ERR_OVERFLOW = 2'd1;
    localparam err_code_t ERR_PAREN    = 2'd2;

    typedef enum logic [1:0] {
        CLS_OPERAND,
        CLS_OPERATOR,
        CLS_LPAREN,
        CLS_RPAREN
    } tok_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUSH,
        ST_CHECK,
        ST_FINISH
    } itp_state_t;

    typedef struct packed {
        logic      latch_in;
        logic      rd_issue;
        logic      pop;
        logic      push;
        logic      emit_en;
        logic      emit_top;
        err_code_t set_err;
        logic      set_flush;
        logic      finish;
    } itp_cmd_t;

    typedef struct packed {
        tok_class_t cls;
        logic       last;
        logic       flushing;
        logic       empty;
        logic       top_lparen;
        logic       top_ge;
        logic       can_emit;
        logic       pend_valid;
        logic       out_free;
    } itp_status_t;

    function automatic tok_class_t sym_class(input logic [7:0] sym);
        tok_class_t cls;
        unique case (sym)
            SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_CARET: cls = CLS_OPERATOR;
            SYM_LPAREN: cls = CLS_LPAREN;
            SYM_RPAREN: cls = CLS_RPAREN;
            default:    cls = CLS_OPERAND;
        endcase
        return cls;
    endfunction

    function automatic op_code_t sym_code(input logic [7:0] sym);
        op_code_t code;
        unique case (sym)
            SYM_PLUS:  code = OP_ADD;
            SYM_MINUS: code = OP_SUB;
            SYM_STAR:  code = OP_MUL;
            SYM_SLASH: code = OP_DIV;
            SYM_CARET: code = OP_POW;
            default:   code = OP_LPAREN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_ascii(input op_code_t code);
        logic [7:0] sym;
        unique case (code)
            OP_ADD:  sym = SYM_PLUS;
            OP_SUB:  sym = SYM_MINUS;
            OP_MUL:  sym = SYM_STAR;
            OP_DIV:  sym = SYM_SLASH;
            OP_POW:  sym = SYM_CARET;
            default: sym = SYM_LPAREN;
        endcase
        return sym;
    endfunction

    function automatic logic [1:0] code_prec(input op_code_t code);
        logic [1:0] prec;
        unique case (code)
            OP_ADD, OP_SUB: prec = 2'd1;
            OP_MUL, OP_DIV: prec = 2'd2;
            OP_POW:         prec = 2'd3;
            default:        prec = 2'd0;
        endcase
        return prec;
    endfunction

endpackage

// ===== rtl/core/itp_ifs.sv =====
// Valid/ready channel interfaces of the infix to postfix converter:
// the token input channel and the postfix result channel.
// Depends on nothing.
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       expr_last;

    modport source (output valid, output symbol, output expr_last, input ready);
    modport sink (input valid, input symbol, input expr_last, output ready);
endinterface

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expr_end;
    logic [1:0] error;

    modport source (output valid, output out_symbol, output run_last, output expr_end,
                    output error, input ready);
    modport sink (input valid, input out_symbol, input run_last, input expr_end,
                  input error, output ready);
endinterface

// ===== rtl/core/itp_datapath.sv =====
// Datapath of the infix to postfix converter: token register, operator stack
// memory, stack count, error flag, pending result and output register.
// Depends on itp_pkg and itp_out_if.
module itp_datapath
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      symbol,
    input  logic            expr_last,
    input  itp_cmd_t        cmd,
    output itp_status_t     status,
    itp_out_if.source       postfix
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    op_code_t       stack_mem [STACK_DEPTH];
    op_code_t       rd_data_reg;

    logic [7:0]     sym_reg;
    logic           last_reg;
    logic           flushing_reg;
    logic           flushing_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    err_code_t      err_reg;
    err_code_t      err_next;

    logic           pend_valid_reg;
    logic           pend_valid_next;
    logic [7:0]     pend_sym_reg;
    logic [7:0]     pend_sym_next;
    err_code_t      pend_err_reg;
    err_code_t      pend_err_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_sym_reg;
    logic [7:0]     out_sym_next;
    logic           out_run_reg;
    logic           out_run_next;
    logic           out_end_reg;
    logic           out_end_next;
    err_code_t      out_err_reg;
    err_code_t      out_err_next;

    logic           full;
    logic           empty;
    logic           out_free;
    logic           load_out;
    logic [CW-1:0]  count_dec;
    logic [AW-1:0]  rd_idx;
    logic [AW-1:0]  wr_idx;
    op_code_t       push_code;
    err_code_t      err_req;

    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CW'(1);
    assign rd_idx    = count_dec[AW-1:0];
    assign wr_idx    = count_reg[AW-1:0];
    assign push_code = (sym_class(sym_reg) == CLS_LPAREN) ? OP_LPAREN : sym_code(sym_reg);
    assign out_free  = !out_valid_reg || postfix.ready;
    assign load_out  = (cmd.emit_en && pend_valid_reg)
                     || (cmd.finish && (pend_valid_reg || last_reg));

    assign status.cls        = sym_class(sym_reg);
    assign status.last       = last_reg;
    assign status.flushing   = flushing_reg;
    assign status.empty      = empty;
    assign status.top_lparen = (rd_data_reg >= OP_LPAREN);
    assign status.top_ge     = (code_prec(rd_data_reg) >= code_prec(sym_code(sym_reg)));
    assign status.can_emit   = !pend_valid_reg || out_free;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign postfix.valid      = out_valid_reg;
    assign postfix.out_symbol = out_sym_reg;
    assign postfix.run_last   = out_run_reg;
    assign postfix.expr_end   = out_end_reg;
    assign postfix.error      = out_err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            stack_mem[wr_idx] <= push_code;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= stack_mem[rd_idx];
        end
        if (cmd.latch_in)
        begin
            sym_reg  <= symbol;
            last_reg <= expr_last;
        end
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_run_reg  <= out_run_next;
        out_end_reg  <= out_end_next;
        out_err_reg  <= out_err_next;
    end

    always_comb
    begin
        err_req = cmd.set_err;
        if (cmd.push && full)
        begin
            err_req = ERR_OVERFLOW;
        end

        if (cmd.finish && last_reg)
        begin
            err_next = ERR_NONE;
        end
        else if (err_reg == ERR_NONE)
        begin
            err_next = err_req;
        end
        else
        begin
            err_next = err_reg;
        end

        if (cmd.finish && last_reg)
        begin
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            count_next = count_dec;
        end
        else if (cmd.push && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        if (cmd.latch_in || cmd.finish)
        begin
            flushing_next = 1'b0;
        end
        else if (cmd.set_flush)
        begin
            flushing_next = 1'b1;
        end
        else
        begin
            flushing_next = flushing_reg;
        end

        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        if (cmd.emit_en)
        begin
            pend_valid_next = 1'b1;
            pend_sym_next   = cmd.emit_top ? code_ascii(rd_data_reg) : sym_reg;
            pend_err_next   = err_reg;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end

        out_sym_next = out_sym_reg;
        out_run_next = out_run_reg;
        out_end_next = out_end_reg;
        out_err_next = out_err_reg;
        if (load_out)
        begin
            if (cmd.finish)
            begin
                out_sym_next = pend_valid_reg ? pend_sym_reg : SYM_NONE;
                out_run_next = 1'b1;
                out_end_next = last_reg;
                out_err_next = last_reg ? err_reg : pend_err_reg;
            end
            else
            begin
                out_sym_next = pend_sym_reg;
                out_run_next = 1'b0;
                out_end_next = 1'b0;
                out_err_next = pend_err_reg;
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (postfix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            err_reg        <= ERR_NONE;
            flushing_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            err_reg        <= err_next;
            flushing_reg   <= flushing_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("A push into a stack with room did not raise the count.");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && last_reg |=> count_reg == '0 && err_reg == ERR_NONE)
        else $error("End of expression did not clear the stack and error flag.");

    a_pend_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |-> !pend_valid_reg)
        else $error("A new token was taken while a result was still pending.");

    a_no_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("The output register was overwritten before its beat was taken.");

endmodule

// ===== rtl/core/itp_controller.sv =====
// Controller of the infix to postfix converter: state machine that sequences
// token decode, stack walks, pushes, the final flush and result release.
// Depends on itp_pkg.
module itp_controller
    import itp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  itp_status_t status,
    output logic        in_ready,
    output itp_cmd_t    cmd
);

    itp_state_t state_reg;
    itp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_READ;
                end
            end

            ST_READ:
            begin
                if (status.flushing)
                begin
                    if (status.empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_EVAL;
                    end
                end
                else
                begin
                    unique case (status.cls)
                        CLS_OPERAND:
                        begin
                            if (status.can_emit)
                            begin
                                cmd.emit_en = 1'b1;
                                state_next  = ST_CHECK;
                            end
                        end
                        CLS_LPAREN:
                        begin
                            state_next = ST_PUSH;
                        end
                        CLS_OPERATOR:
                        begin
                            if (status.empty)
                            begin
                                state_next = ST_PUSH;
                            end
                            else
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = ST_EVAL;
                            end
                        end
                        CLS_RPAREN:
                        begin
                            if (status.empty)
                            begin
                                cmd.set_err = ERR_PAREN;
                                state_next  = ST_CHECK;
                            end
                            else
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = ST_EVAL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end

            ST_EVAL:
            begin
                if (status.flushing)
                begin
                    if (status.top_lparen)
                    begin
                        cmd.pop     = 1'b1;
                        cmd.set_err = ERR_PAREN;
                        state_next  = ST_READ;
                    end
                    else if (status.can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.emit_en  = 1'b1;
                        cmd.emit_top = 1'b1;
                        state_next   = ST_READ;
                    end
                end
                else if (status.cls == CLS_RPAREN)
                begin
                    if (status.top_lparen)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_CHECK;
                    end
                    else if (status.can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.emit_en  = 1'b1;
                        cmd.emit_top = 1'b1;
                        state_next   = ST_READ;
                    end
                end
                else
                begin
                    if (status.top_lparen || !status.top_ge)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (status.can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.emit_en  = 1'b1;
                        cmd.emit_top = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end

            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (status.last)
                begin
                    cmd.set_flush = 1'b1;
                    state_next    = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (status.out_free || !(status.pend_valid || status.last))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_READ)
        else $error("An accepted token did not start a stack walk.");

    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_IDLE)
        else $error("Token completion did not return to idle.");

    a_one_stack_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("Push and pop were issued in the same cycle.");

endmodule

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// Top level of the infix to postfix converter (shunting yard).
// Depends on itp_pkg, itp_ifs, itp_controller and itp_datapath.
//
// Usage: infix tokens arrive one ASCII character per beat on the token
// channel, with expr_last set on the final token of an expression. The
// postfix channel delivers the output tokens, each beat carrying run_last
// on the last result of its token, expr_end on the final result of the
// expression, and the error code (overflow or unmatched parenthesis).
// A final token that yields nothing still delivers one beat with symbol 0.
// Acceptance: the token channel is ready only while idle. Each operator
// popped takes a registered stack read, then a judgment; a walk ending on
// an entry left unpopped or a matching '(' also ends with a read and a
// judgment, a push takes a state of its own, and a final token starts the
// flush, then pops each entry with a read and a judgment. Output path: a
// result is held back until the next one (or the end of the token) is known,
// so it waits in the pending result before it enters the output register.
// Reset clears the stack count, the error flag and all valid flags; the
// stack memory itself is not cleared. When the receiver stalls, the output
// register and the pending result fill and the stack walk waits in place;
// no new token is accepted until its last result is in the output register.
module infix_to_postfix_converter_top
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    itp_in_if.sink    token,
    itp_out_if.source postfix
);

    itp_cmd_t    cmd;
    itp_status_t status;
    logic        in_ready;

    assign token.ready = in_ready;

    itp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (token.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (token.symbol),
        .expr_last (token.expr_last),
        .cmd       (cmd),
        .status    (status),
        .postfix   (postfix)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for infix_to_postfix_converter_top: random infix token streams
// are driven in bursts and the postfix beats are checked against an operator stack predictor.
// Depends on itp_pkg, the itp_ifs interfaces and the converter RTL.
module testbench;
    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       drain;
    } token_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       run_last;
        logic       expr_end;
        err_code_t  error;
    } beat_t;

    logic clk;
    logic rst_n;

    itp_in_if  token_if();
    itp_out_if postfix_if();

    infix_to_postfix_converter_top u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .token   (token_if),
        .postfix (postfix_if)
    );

    token_t      token_queue[$];
    beat_t       postfix_expected[$];
    op_code_t    opstack[ITP_STACK_DEPTH];
    int unsigned stack_fill = 0;
    err_code_t   sticky_err = ERR_NONE;
    int unsigned fail_count = 0;

    int unsigned burst_left = 8;
    int unsigned gap_left = 0;

    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_mode = 0;
    logic [7:0]  rx_pattern = 8'hFF;

    always #2 clk = ~clk;

    function automatic logic is_operator(input logic [7:0] sym);
        return sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR
            || sym == SYM_SLASH || sym == SYM_CARET;
    endfunction

    function automatic op_code_t op_of(input logic [7:0] sym);
        op_code_t code;
        case (sym)
            SYM_PLUS:  code = OP_ADD;
            SYM_MINUS: code = OP_SUB;
            SYM_STAR:  code = OP_MUL;
            SYM_SLASH: code = OP_DIV;
            default:   code = OP_POW;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] char_of(input op_code_t code);
        logic [7:0] sym;
        case (code)
            OP_ADD:  sym = SYM_PLUS;
            OP_SUB:  sym = SYM_MINUS;
            OP_MUL:  sym = SYM_STAR;
            OP_DIV:  sym = SYM_SLASH;
            default: sym = SYM_CARET;
        endcase
        return sym;
    endfunction

    function automatic int binding(input op_code_t code);
        int level;
        case (code)
            OP_ADD, OP_SUB: level = 1;
            OP_MUL, OP_DIV: level = 2;
            OP_POW:         level = 3;
            default:        level = 0;
        endcase
        return level;
    endfunction

    function automatic void note_error(input err_code_t code);
        if (sticky_err == ERR_NONE)
            sticky_err = code;
    endfunction

    function automatic void push_entry(input op_code_t code);
        if (stack_fill >= ITP_STACK_DEPTH)
            note_error(ERR_OVERFLOW);
        else
        begin
            opstack[stack_fill] = code;
            stack_fill++;
        end
    endfunction

    function automatic beat_t make_beat(input logic [7:0] sym);
        beat_t b;
        b.symbol   = sym;
        b.run_last = 1'b0;
        b.expr_end = 1'b0;
        b.error    = sticky_err;
        return b;
    endfunction

    function automatic void predict_postfix(input logic [7:0] sym, input logic last);
        beat_t    run[$];
        op_code_t top;
        logic     stop;
        int       idx;
        stop = 1'b0;
        if (is_operator(sym))
        begin
            while (stack_fill > 0 && !stop)
            begin
                top = opstack[stack_fill - 1];
                if (top == OP_LPAREN || binding(top) < binding(op_of(sym)))
                    stop = 1'b1;
                else
                begin
                    run.insert(run.size(), make_beat(char_of(top)));
                    stack_fill--;
                end
            end
            push_entry(op_of(sym));
        end
        else if (sym == SYM_LPAREN)
            push_entry(OP_LPAREN);
        else if (sym == SYM_RPAREN)
        begin
            while (stack_fill > 0 && !stop)
            begin
                top = opstack[stack_fill - 1];
                stack_fill--;
                if (top == OP_LPAREN)
                    stop = 1'b1;
                else
                    run.insert(run.size(), make_beat(char_of(top)));
            end
            if (!stop)
                note_error(ERR_PAREN);
        end
        else
            run.insert(run.size(), make_beat(sym));

        if (last)
        begin
            while (stack_fill > 0)
            begin
                top = opstack[stack_fill - 1];
                stack_fill--;
                if (top == OP_LPAREN)
                    note_error(ERR_PAREN);
                else
                    run.insert(run.size(), make_beat(char_of(top)));
            end
            if (run.size() == 0)
                run.insert(run.size(), make_beat(SYM_NONE));
            idx = run.size() - 1;
            run[idx].expr_end = 1'b1;
            run[idx].error    = sticky_err;
            stack_fill = 0;
            sticky_err = ERR_NONE;
        end

        if (run.size() > 0)
        begin
            idx = run.size() - 1;
            run[idx].run_last = 1'b1;
        end
        foreach (run[i])
            postfix_expected.insert(postfix_expected.size(), run[i]);
    endfunction

    task automatic report(input string field, input int exp_val, input int act_val);
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
        fail_count++;
    endtask

    // Stimulus construction.

    task automatic add_token(input logic [7:0] sym, input logic last);
        token_t t;
        t.symbol = sym;
        t.last   = last;
        t.drain  = 1'b0;
        token_queue.insert(token_queue.size(), t);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_token(s[i], i == s.len() - 1);
    endtask

    task automatic close_expr();
        token_queue[token_queue.size() - 1].last = 1'b1;
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] sym;
        if ($urandom_range(0, 3) != 0)
            sym = 8'h61 + 8'($urandom_range(0, 25));
        else
        begin
            sym = 8'($urandom_range(0, 255));
            while (is_operator(sym) || sym == SYM_LPAREN || sym == SYM_RPAREN)
                sym = 8'($urandom_range(0, 255));
        end
        return sym;
    endfunction

    function automatic logic [7:0] rand_operator();
        return char_of(op_code_t'($urandom_range(0, 4)));
    endfunction

    task automatic add_operand_or_group(input int depth);
        if (depth > 0 && $urandom_range(0, 2) == 0)
        begin
            add_token(SYM_LPAREN, 1'b0);
            add_expr(depth - 1);
            add_token(SYM_RPAREN, 1'b0);
        end
        else
            add_token(rand_operand(), 1'b0);
    endtask

    task automatic add_expr(input int depth);
        int terms;
        terms = $urandom_range(0, 4);
        add_operand_or_group(depth);
        repeat (terms)
        begin
            add_token(rand_operator(), 1'b0);
            add_operand_or_group(depth);
        end
    endtask

    task automatic add_nest(input int levels, input logic mixed);
        repeat (levels)
        begin
            if (mixed && $urandom_range(0, 1) == 1)
            begin
                add_token(rand_operand(), 1'b0);
                add_token(rand_operator(), 1'b0);
            end
            add_token(SYM_LPAREN, 1'b0);
        end
        add_token(rand_operand(), 1'b1);
    endtask

    task automatic add_broken();
        int len;
        int pick;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 5);
            if (pick < 2)
                add_token(rand_operand(), i == len - 1);
            else if (pick < 4)
                add_token(rand_operator(), i == len - 1);
            else if (pick == 4)
                add_token(SYM_LPAREN, i == len - 1);
            else
                add_token(SYM_RPAREN, i == len - 1);
        end
    endtask

    task automatic add_noise();
        int len;
        len = $urandom_range(1, 8);
        repeat (len)
            add_token(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    endtask

    // Token driver.
    always @(posedge clk)
    begin
        if (rst_n && (!token_if.valid || token_if.ready))
        begin
            if (gap_left != 0)
            begin
                token_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (token_queue.size() == 0 || (token_queue[0].drain
                     && (postfix_expected.size() != 0 || (token_if.valid && token_if.ready))))
                token_if.valid <= 1'b0;
            else
            begin
                token_if.valid     <= 1'b1;
                token_if.symbol    <= token_queue[0].symbol;
                token_if.expr_last <= token_queue[0].last;
                token_queue.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 3) == 0)
                        gap_left <= 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(10, 30);
                    else
                        gap_left <= $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Postfix receiver with its own stall pattern and one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                postfix_if.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (rx_cycle == 1500)
            begin
                postfix_if.ready <= 1'b0;
                hold_left <= 300;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode    <= $urandom_range(0, 3);
                    rx_pattern <= 8'($urandom_range(0, 255));
                    mode_left  <= $urandom_range(20, 120);
                end
                else
                    mode_left <= mode_left - 1;
                case (rx_mode)
                    0:       postfix_if.ready <= 1'b1;
                    1:       postfix_if.ready <= $urandom_range(0, 1) == 1;
                    2:       postfix_if.ready <= $urandom_range(0, 3) == 0;
                    default: postfix_if.ready <= rx_pattern[rx_cycle % 8];
                endcase
            end
        end
    end

    // Prediction on accepted tokens and checking of accepted postfix beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_if.valid && token_if.ready)
                predict_postfix(token_if.symbol, token_if.expr_last);
            if (postfix_if.valid && postfix_if.ready)
            begin
                if (postfix_expected.size() == 0)
                begin
                    $error("unexpected postfix beat: out_symbol 0x%0h", postfix_if.out_symbol);
                    fail_count++;
                end
                else
                begin
                    if (postfix_if.out_symbol !== postfix_expected[0].symbol)
                        report("out_symbol", postfix_expected[0].symbol, postfix_if.out_symbol);
                    if (postfix_if.run_last !== postfix_expected[0].run_last)
                        report("run_last", postfix_expected[0].run_last, postfix_if.run_last);
                    if (postfix_if.expr_end !== postfix_expected[0].expr_end)
                        report("expr_end", postfix_expected[0].expr_end, postfix_if.expr_end);
                    if (postfix_if.error !== postfix_expected[0].error)
                        report("error", postfix_expected[0].error, postfix_if.error);
                    postfix_expected.pop_front();
                end
            end
        end
    end

    initial
    begin
        int random_count;
        int expr_idx;
        int mark;
        int kind;

        clk = 1'b0;
        rst_n = 1'b0;
        token_if.valid = 1'b0;
        token_if.symbol = 8'h00;
        token_if.expr_last = 1'b0;
        postfix_if.ready = 1'b0;

        add_text("a");
        add_text("a+b*c^d-e/f");
        add_text("(a+b)*c");
        add_text(")");
        add_text("(");
        add_token(8'h00, 1'b0);
        add_token(SYM_STAR, 1'b0);
        add_token(8'hFF, 1'b1);
        add_text("a+b)");

        random_count = 0;
        expr_idx = 0;
        while (random_count < 450)
        begin
            mark = token_queue.size();
            kind = $urandom_range(0, 19);
            if (expr_idx == 2)
                add_nest(34, 1'b0);
            else if (expr_idx % 30 == 17)
                add_nest($urandom_range(20, 36), 1'b1);
            else if (kind < 14)
            begin
                add_expr($urandom_range(0, 3));
                close_expr();
            end
            else if (kind < 17)
                add_broken();
            else
                add_noise();
            if (expr_idx == 0 || $urandom_range(0, 14) == 0)
                token_queue[mark].drain = 1'b1;
            random_count += token_queue.size() - mark;
            expr_idx++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (token_queue.size() != 0 || token_if.valid)
            @(posedge clk);
        while (postfix_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (fail_count == 0 && postfix_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
